>>> design/lexicographic_next_permutation_defines.svh
// Assertion helpers used by the RTL file that checks its own logic.
// Each use expects i_clk and i_rst_n in scope.
`ifndef LEXICOGRAPHIC_NEXT_PERMUTATION_DEFINES_SVH
`define LEXICOGRAPHIC_NEXT_PERMUTATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LNP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lnp_pkg.sv
package lnp_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 8;
    localparam int READ_W   = 8;

    typedef logic [READ_W-1:0] t_read_value;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } t_op;

    // Compare direction of the shared unit.
    typedef enum logic {
        CMP_ASCENT = 1'b0,
        CMP_SUCC   = 1'b1
    } t_cmp_mode;

endpackage

>>> design/lnp_req_if.sv
interface lnp_req_if;
    logic                          valid;
    logic                          ready;
    logic [lnp_pkg::OPCODE_W-1:0]  opcode;
    logic [lnp_pkg::INDEX_W-1:0]   index;
    logic [lnp_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output opcode, output index, output value, input ready);
    modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

>>> design/lnp_rsp_if.sv
interface lnp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lnp_pkg::READ_W-1:0]  read_value;
    logic                        advanced;

    modport source (output valid, output read_value, output advanced, input ready);
    modport sink   (input valid, input read_value, input advanced, output ready);
endinterface

>>> design/lnp_ram.sv
module lnp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lnp_cmp.sv
module lnp_cmp #(
    parameter int VALUE_BITS = 8
) (
    input  lnp_pkg::t_cmp_mode     i_mode,
    input  logic [VALUE_BITS-1:0]  i_data,
    input  logic [VALUE_BITS-1:0]  i_base,
    output logic                   o_hit
);

    // Ascent: data below the element to its right. Successor: data above the pivot.
    always_comb begin
        unique case (i_mode)
            lnp_pkg::CMP_ASCENT: o_hit = (i_data < i_base);
            lnp_pkg::CMP_SUCC:   o_hit = (i_base < i_data);
            default:             o_hit = 1'b0;
        endcase
    end

endmodule

>>> design/lexicographic_next_permutation.sv
// Holds GRID_SIDE*GRID_SIDE elements of VALUE_BITS bits (grid cells in row-major
// order) in a single RAM with one write and one registered read port. Each item
// writes one element, reads one element, or steps the whole array to its next
// lexicographic permutation; every item returns exactly one result item.
// A write or a no-op goes from accept straight to posting its result; a read
// first waits for the registered RAM data. An advance scans down from the top
// for the rightmost ascent, scans down again for the rightmost element above
// the pivot, swaps them and reverses the suffix pair by pair, then posts the
// result. It runs serially through the single RAM read port and the one shared
// comparator. When there is no ascent the array is left alone and advanced
// reads 0. The block takes no new item while one is in work, but a finished
// result waits in an output register so the next item can be accepted before
// it is taken. Reads of elements never written return undefined data.
`include "lexicographic_next_permutation_defines.svh"

module lexicographic_next_permutation #(
    parameter int GRID_SIDE  = 4,
    parameter int VALUE_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lnp_req_if.sink      i_req,
    lnp_rsp_if.source    o_rsp
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);

    typedef logic [AW-1:0]         t_addr;
    typedef logic [VALUE_BITS-1:0] t_elem;

    localparam t_addr LAST = t_addr'(CELLS - 1);
    localparam t_addr ONE  = t_addr'(1);
    localparam t_addr ZERO = t_addr'(0);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_RDWAIT  = 10'b00_0000_0010,
        S_SCAN1   = 10'b00_0000_0100,
        S_SCAN2   = 10'b00_0000_1000,
        S_SWAP    = 10'b00_0001_0000,
        S_REV_RDI = 10'b00_0010_0000,
        S_REV_RDJ = 10'b00_0100_0000,
        S_REV_WRI = 10'b00_1000_0000,
        S_REV_WRJ = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    // Control state
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_more, n_more;   // scan still has addresses to issue
    logic   r_dv, n_dv;       // RAM data this cycle belongs to the scan

    // Datapath
    lnp_pkg::t_read_value r_out_rd, n_out_rd;
    logic                 r_out_adv, n_out_adv;
    lnp_pkg::t_read_value r_res_rd, n_res_rd;
    logic                 r_res_adv, n_res_adv;
    logic                 r_rd_ok, n_rd_ok;
    t_addr                r_ra, n_ra;         // next scan read address
    t_addr                r_da, n_da;         // address of the data now on the RAM output
    t_elem                r_prev, n_prev;     // element right of the one being checked
    t_addr                r_piv_idx, n_piv_idx;
    t_elem                r_piv_val, n_piv_val;
    t_addr                r_succ_idx, n_succ_idx;
    t_elem                r_hold, n_hold;
    t_addr                r_ri, n_ri;
    t_addr                r_rj, n_rj;

    // RAM and compare unit hookup
    logic               ram_we;
    t_addr              ram_waddr;
    t_elem              ram_wdata;
    t_addr              ram_raddr;
    t_elem              ram_rdata;
    lnp_pkg::t_cmp_mode cmp_mode;
    t_elem              cmp_base;
    logic               cmp_hit;

    logic  req_fire;
    logic  in_range;
    t_addr ri_next;
    t_addr rj_next;

    // Conditions watched by the checks below
    logic  rev_pair;
    logic  succ_data;
    logic  adv_out;

    lnp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CELLS),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    lnp_cmp #(
        .VALUE_BITS(VALUE_BITS)
    ) u_cmp (
        .i_mode(cmp_mode),
        .i_data(ram_rdata),
        .i_base(cmp_base),
        .o_hit (cmp_hit)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign req_fire        = i_req.valid && (r_state == S_IDLE);
    assign in_range        = (32'(i_req.index) < 32'(CELLS));
    assign ri_next         = r_ri + ONE;
    assign rj_next         = r_rj - ONE;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.advanced   = r_out_adv;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_rsp.ready;  // drop a result once taken
        n_out_rd    = r_out_rd;
        n_out_adv   = r_out_adv;
        n_res_rd    = r_res_rd;
        n_res_adv   = r_res_adv;
        n_rd_ok     = r_rd_ok;
        n_more      = r_more;
        n_dv        = 1'b0;
        n_ra        = r_ra;
        n_da        = r_da;
        n_prev      = r_prev;
        n_piv_idx   = r_piv_idx;
        n_piv_val   = r_piv_val;
        n_succ_idx  = r_succ_idx;
        n_hold      = r_hold;
        n_ri        = r_ri;
        n_rj        = r_rj;

        ram_we    = 1'b0;
        ram_waddr = ZERO;
        ram_wdata = r_piv_val;
        ram_raddr = ZERO;
        cmp_mode  = lnp_pkg::CMP_ASCENT;
        cmp_base  = r_prev;

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    unique case (lnp_pkg::t_op'(i_req.opcode))
                        lnp_pkg::OP_WRITE: begin
                            // Ignore writes past the grid.
                            ram_we    = in_range;
                            ram_waddr = t_addr'(i_req.index);
                            ram_wdata = t_elem'(i_req.value);
                            n_res_rd  = '0;
                            n_res_adv = 1'b0;
                            n_state   = S_DONE;
                        end
                        lnp_pkg::OP_READ: begin
                            ram_raddr = t_addr'(i_req.index);
                            n_rd_ok   = in_range;
                            n_state   = S_RDWAIT;
                        end
                        lnp_pkg::OP_ADVANCE: begin
                            n_ra    = LAST;
                            n_more  = 1'b1;
                            n_state = S_SCAN1;
                        end
                        default: begin
                            n_res_rd  = '0;
                            n_res_adv = 1'b0;
                            n_state   = S_DONE;
                        end
                    endcase
                end
            end

            S_RDWAIT: begin
                n_res_rd  = r_rd_ok ? lnp_pkg::t_read_value'(ram_rdata) : '0;
                n_res_adv = 1'b0;
                n_state   = S_DONE;
            end

            S_SCAN1: begin
                // Issue one read per cycle from the top down.
                if (r_more) begin
                    ram_raddr = r_ra;
                    n_da      = r_ra;
                    n_dv      = 1'b1;
                    n_ra      = r_ra - ONE;
                    n_more    = (r_ra != ZERO);
                end
                cmp_mode = lnp_pkg::CMP_ASCENT;
                cmp_base = r_prev;
                if (r_dv) begin
                    if (r_da != LAST && cmp_hit) begin
                        n_piv_idx = r_da;
                        n_piv_val = ram_rdata;
                        n_ra      = LAST;
                        n_more    = 1'b1;
                        n_dv      = 1'b0;
                        n_state   = S_SCAN2;
                    end else if (r_da == ZERO) begin
                        // Non-increasing array: last permutation, leave it.
                        n_res_rd  = '0;
                        n_res_adv = 1'b0;
                        n_state   = S_DONE;
                    end else begin
                        n_prev = ram_rdata;
                    end
                end
            end

            S_SCAN2: begin
                if (r_more) begin
                    ram_raddr = r_ra;
                    n_da      = r_ra;
                    n_dv      = 1'b1;
                    n_ra      = r_ra - ONE;
                    n_more    = (r_ra != ZERO);
                end
                cmp_mode = lnp_pkg::CMP_SUCC;
                cmp_base = r_piv_val;
                // The element right of the pivot always qualifies; stop there at the latest.
                if (r_dv && (cmp_hit || r_da == r_piv_idx + ONE)) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_piv_idx;
                    ram_wdata  = ram_rdata;
                    n_succ_idx = r_da;
                    n_dv       = 1'b0;
                    n_state    = S_SWAP;
                end
            end

            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_succ_idx;
                ram_wdata = r_piv_val;
                n_ri      = r_piv_idx + ONE;
                n_rj      = LAST;
                if (r_piv_idx + ONE < LAST) begin
                    n_state = S_REV_RDI;
                end else begin
                    n_res_rd  = '0;
                    n_res_adv = 1'b1;
                    n_state   = S_DONE;
                end
            end

            S_REV_RDI: begin
                ram_raddr = r_ri;
                n_state   = S_REV_RDJ;
            end

            S_REV_RDJ: begin
                ram_raddr = r_rj;
                n_hold    = ram_rdata;
                n_state   = S_REV_WRI;
            end

            S_REV_WRI: begin
                ram_we    = 1'b1;
                ram_waddr = r_ri;
                ram_wdata = ram_rdata;
                n_state   = S_REV_WRJ;
            end

            S_REV_WRJ: begin
                ram_we    = 1'b1;
                ram_waddr = r_rj;
                ram_wdata = r_hold;
                // Prefetch the next left element while writing the right one.
                ram_raddr = ri_next;
                n_ri      = ri_next;
                n_rj      = rj_next;
                if (ri_next < rj_next) begin
                    n_state = S_REV_RDJ;
                end else begin
                    n_res_rd  = '0;
                    n_res_adv = 1'b1;
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free or being emptied.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_res_rd;
                    n_out_adv   = r_res_adv;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_more      <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_more      <= n_more;
            r_dv        <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rd   <= n_out_rd;
        r_out_adv  <= n_out_adv;
        r_res_rd   <= n_res_rd;
        r_res_adv  <= n_res_adv;
        r_rd_ok    <= n_rd_ok;
        r_ra       <= n_ra;
        r_da       <= n_da;
        r_prev     <= n_prev;
        r_piv_idx  <= n_piv_idx;
        r_piv_val  <= n_piv_val;
        r_succ_idx <= n_succ_idx;
        r_hold     <= n_hold;
        r_ri       <= n_ri;
        r_rj       <= n_rj;
    end

    assign rev_pair  = (r_state == S_REV_RDJ) || (r_state == S_REV_WRI) ||
                       (r_state == S_REV_WRJ);
    assign succ_data = (r_state == S_SCAN2) && r_dv;
    assign adv_out   = r_out_valid && r_out_adv;

    // An accepted item always leaves idle.
    `LNP_ASSERT_NEXT(a_fire_leaves_idle, req_fire, r_state != S_IDLE, "accepted item stayed idle")

    // Reversal only runs while the two pointers have not crossed.
    `LNP_ASSERT_NOW(a_rev_order, rev_pair, r_ri < r_rj, "reverse pointers crossed")

    // The successor scan never looks at or below the pivot.
    `LNP_ASSERT_NOW(a_succ_above_pivot, succ_data, r_da > r_piv_idx, "scan passed the pivot")

    // A result never carries both a read value and an advance flag.
    `LNP_ASSERT_NOW(a_rsp_exclusive, adv_out, r_out_rd == '0, "advance result has read data")

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_SIDE      = 4;
    localparam int VALUE_BITS     = 8;
    localparam int CELLS          = GRID_SIDE * GRID_SIDE;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int ITEM_TARGET    = 400;
    // The long receiver hold-off below outlasts the slowest advance.
    localparam int BACKLOG_AT     = 150;
    localparam int BACKLOG_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;

    // Opcode 3 has no name in the package: the block treats it as a no-op.
    localparam logic [lnp_pkg::OPCODE_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [lnp_pkg::OPCODE_W-1:0] opcode;
        logic [lnp_pkg::INDEX_W-1:0]  index;
        logic [lnp_pkg::VALUE_W-1:0]  value;
    } t_perm_cmd;

    typedef struct packed {
        lnp_pkg::t_read_value read_value;
        logic                 advanced;
    } t_perm_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lnp_req_if req_if ();
    lnp_rsp_if rsp_if ();

    lexicographic_next_permutation #(
        .GRID_SIDE  (GRID_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Commands waiting to be offered, and replies predicted for accepted commands.
    t_perm_cmd   pending_cmds[$];
    t_perm_reply expected_replies[$];

    // Mirror of the block's element store, updated as each command is accepted.
    logic [VALUE_BITS-1:0] grid_cells [CELLS];

    int error_count    = 0;
    int writes_seen    = 0;
    int reads_seen     = 0;
    int steps_taken    = 0;
    int steps_at_last  = 0;
    int nops_seen      = 0;
    int replies_taken  = 0;
    int req_gap        = 0;
    int src_quiet      = 0;
    int sink_stall     = 0;
    int sink_quiet     = 0;
    int backlog_hold   = 0;
    int idle_cycles    = 0;

    // Step the mirrored array to its next lexicographic permutation.
    // Return 0 and leave the array alone when it is already non-increasing.
    function automatic logic step_to_next_permutation();
        int                    pos;
        int                    succ;
        int                    lo;
        int                    hi;
        logic [VALUE_BITS-1:0] pivot;
        logic [VALUE_BITS-1:0] held;
        pos = CELLS - 1;
        while (pos > 0 && grid_cells[pos - 1] >= grid_cells[pos])
            pos--;
        if (pos == 0)
            return 1'b0;
        pivot = grid_cells[pos - 1];
        // An element above the pivot exists at pos, so this scan stops there at the latest.
        succ = CELLS - 1;
        while (grid_cells[succ] <= pivot)
            succ--;
        grid_cells[pos - 1] = grid_cells[succ];
        grid_cells[succ]    = pivot;
        lo = pos;
        hi = CELLS - 1;
        while (lo < hi) begin
            held           = grid_cells[lo];
            grid_cells[lo] = grid_cells[hi];
            grid_cells[hi] = held;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    // Apply one accepted command to the mirror and work out its reply.
    function automatic t_perm_reply predict_reply(t_perm_cmd cmd);
        t_perm_reply reply;
        reply = '0;
        case (cmd.opcode)
            lnp_pkg::OP_WRITE: begin
                writes_seen++;
                if (cmd.index < CELLS)
                    grid_cells[cmd.index] = VALUE_BITS'(cmd.value);
            end
            lnp_pkg::OP_READ: begin
                reads_seen++;
                if (cmd.index < CELLS)
                    reply.read_value = lnp_pkg::READ_W'(grid_cells[cmd.index]);
            end
            lnp_pkg::OP_ADVANCE: begin
                reply.advanced = step_to_next_permutation();
                if (reply.advanced)
                    steps_taken++;
                else
                    steps_at_last++;
            end
            default: begin
                nops_seen++;
            end
        endcase
        return reply;
    endfunction

    // Mostly no gap, some short ones, a few long; now and then a quiet stretch of none.
    function automatic int pick_gap(ref int quiet_left);
        int roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void enqueue_cmd(logic [lnp_pkg::OPCODE_W-1:0] op, int idx, int val);
        t_perm_cmd cmd;
        cmd.opcode = op;
        cmd.index  = lnp_pkg::INDEX_W'(idx);
        cmd.value  = lnp_pkg::VALUE_W'(val);
        pending_cmds.push_back(cmd);
    endfunction

    function automatic int any_index();
        return $urandom_range(0, CELLS - 1);
    endfunction

    function automatic int any_value();
        return $urandom_range(0, 255);
    endfunction

    // Load a non-increasing array (duplicates allowed), shuffle a few cells near the
    // tail so that only a handful of permutations remain, then advance through them.
    function automatic void enqueue_descending_run();
        int                 run_vals [CELLS];
        int                 level;
        int                 drop_max;
        int                 span;
        int                 a;
        int                 b;
        int                 held;
        level    = $urandom_range(0, 255);
        drop_max = $urandom_range(0, 40);
        for (int k = 0; k < CELLS; k++) begin
            run_vals[k] = level;
            level = level - int'($urandom_range(0, drop_max));
            if (level < 0)
                level = 0;
        end
        span = $urandom_range(1, 5);
        repeat ($urandom_range(0, 3)) begin
            a = CELLS - 1 - int'($urandom_range(0, span - 1));
            b = CELLS - 1 - int'($urandom_range(0, span - 1));
            held        = run_vals[a];
            run_vals[a] = run_vals[b];
            run_vals[b] = held;
        end
        for (int k = 0; k < CELLS; k++)
            enqueue_cmd(lnp_pkg::OP_WRITE, k, run_vals[k]);
        repeat ($urandom_range(2, 8)) begin
            enqueue_cmd(lnp_pkg::OP_ADVANCE, any_index(), any_value());
            if ($urandom_range(0, 2) == 0)
                enqueue_cmd(lnp_pkg::OP_READ, any_index(), any_value());
        end
    endfunction

    // One loose command: writes and reads anywhere, advances, and the odd no-op.
    function automatic void enqueue_loose_cmd();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            enqueue_cmd(lnp_pkg::OP_WRITE, any_index(), any_value());
        else if (roll < 7)
            enqueue_cmd(lnp_pkg::OP_READ, any_index(), any_value());
        else if (roll < 9)
            enqueue_cmd(lnp_pkg::OP_ADVANCE, any_index(), any_value());
        else
            enqueue_cmd(OP_NOP, any_index(), any_value());
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Driver: offer the head of the pending queue; drop it and predict its reply
    // once it is accepted, then hold off for a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_replies.push_back(predict_reply(pending_cmds[0]));
                pending_cmds.pop_front();
                req_gap = pick_gap(src_quiet);
            end
            // Keep an offered item steady until the block takes it.
            if (!req_if.valid || req_if.ready) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    req_if.opcode <= pending_cmds[0].opcode;
                    req_if.index  <= pending_cmds[0].index;
                    req_if.value  <= pending_cmds[0].value;
                    req_if.valid  <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted reply against the oldest prediction and
    // stall the reply side at random. Once, hold ready low long enough for the
    // block to fill its output register and stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("replies outstanding", 1, 0);
                end else begin
                    if (rsp_if.read_value !== expected_replies[0].read_value)
                        report_mismatch("read_value", rsp_if.read_value,
                                        expected_replies[0].read_value);
                    if (rsp_if.advanced !== expected_replies[0].advanced)
                        report_mismatch("advanced", rsp_if.advanced,
                                        expected_replies[0].advanced);
                    expected_replies.pop_front();
                end
                replies_taken++;
                if (replies_taken == BACKLOG_AT)
                    backlog_hold = BACKLOG_CYCLES;
            end
            if (backlog_hold > 0) begin
                backlog_hold--;
                rsp_if.ready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                sink_stall = pick_gap(sink_quiet);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no item moved for %0d cycles, %0d commands and %0d replies open",
                         $realtime, idle_cycles, pending_cmds.size(), expected_replies.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid  = 1'b0;
        req_if.opcode = lnp_pkg::OP_WRITE;
        req_if.index  = '0;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;

        // Directed: fill every cell first so nothing unwritten is ever read.
        // The array is strictly descending from 255 to 0 except that the last two
        // cells are swapped, so one advance reaches the last permutation and the
        // next one finds none.
        for (int k = 0; k < CELLS; k++) begin
            if (k == CELLS - 2)
                enqueue_cmd(lnp_pkg::OP_WRITE, k, 0);
            else if (k == CELLS - 1)
                enqueue_cmd(lnp_pkg::OP_WRITE, k, 17);
            else
                enqueue_cmd(lnp_pkg::OP_WRITE, k, 255 - 17 * k);
        end
        enqueue_cmd(lnp_pkg::OP_READ, 0, 0);
        enqueue_cmd(lnp_pkg::OP_READ, CELLS - 1, 255);
        enqueue_cmd(lnp_pkg::OP_ADVANCE, 0, 0);
        enqueue_cmd(lnp_pkg::OP_ADVANCE, CELLS - 1, 255);
        enqueue_cmd(lnp_pkg::OP_READ, CELLS - 2, 0);
        enqueue_cmd(OP_NOP, CELLS - 1, 255);
        enqueue_cmd(lnp_pkg::OP_READ, CELLS - 1, 0);

        // Random: mostly descending runs walked to their end, the rest loose commands.
        while (pending_cmds.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 6)
                enqueue_descending_run();
            else
                repeat ($urandom_range(1, 6)) enqueue_loose_cmd();
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || expected_replies.size() > 0)
            @(posedge i_clk);
        // Let any stray reply show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d writes, %0d reads, %0d no-ops, %0d advances (%0d at last)",
                 writes_seen, reads_seen, nops_seen, steps_taken + steps_at_last,
                 steps_at_last);
        $display("summary: %0d replies checked, random stalls, one %0d-cycle backlog, %0d errors",
                 replies_taken, BACKLOG_CYCLES, error_count);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
